FILE: rtl/cosc_pkg.sv
`timescale 1ns / 1ps

package cosc_pkg;

    localparam int LED_COUNT = 64;
    localparam int LED_W     = 6;
    localparam int PHASE_W   = 16;
    localparam int FREQ_W    = 13;
    localparam int DT_W      = 16;
    localparam int BRIGHT_W  = 16;
    localparam int CFG_W     = 13;
    localparam int CFG_ADDR_W = 2;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_STEP = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_MIN  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_MAX  = 2'd2;

    localparam logic [CFG_W-1:0] FREQ_STEP_RESET = 13'd410;
    localparam logic [CFG_W-1:0] FREQ_MIN_RESET  = 13'd1843;
    localparam logic [CFG_W-1:0] FREQ_MAX_RESET  = 13'd4506;
    localparam logic [FREQ_W-1:0] FREQ_RESET     = 13'd4096;

    // cosine polynomial coefficients, q30
    localparam logic [31:0] COS_C1  = 32'd1324675879;
    localparam logic [31:0] COS_C2  = 32'd272375560;
    localparam logic [31:0] COS_C3  = 32'd22401992;
    localparam logic [31:0] COS_C4  = 32'd987048;
    localparam logic [31:0] Q30_ONE = 32'd1073741824;

endpackage

FILE: rtl/coupled_oscillator_led_strip.sv
`timescale 1ns / 1ps

// load transaction: written straight into the led memories, s_tready stays high
// tick transaction: interior leds run RDOWN, RDNB, the multiply steps and EMIT, which
//   waits on output stalls, then the two end leds run RDOWN and an advance; the single
//   shared 32x32 multiplier runs 14 dependent products per interior led (cosine, ninth
//   power, advance); the first brightness follows the first interior led's advance
// aresetn (sync, active low) resets control, config and m_tvalid, marks all led state unwritten
module coupled_oscillator_led_strip (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // led_number[5:0], phase_value[21:6], freq_value[34:22], time_step[50:35]
    input  logic [cosc_pkg::S_TDATA_W-1:0]     s_tdata,
    // opcode
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pixel_number[5:0], brightness[21:6]
    output logic [cosc_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [cosc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [cosc_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RDOWN = 3'd1;
    localparam logic [2:0] ST_RDNB  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    localparam logic [3:0] SP_SQ     = 4'd0;
    localparam logic [3:0] SP_C4     = 4'd1;
    localparam logic [3:0] SP_C3     = 4'd2;
    localparam logic [3:0] SP_C2     = 4'd3;
    localparam logic [3:0] SP_C1     = 4'd4;
    localparam logic [3:0] SP_POW_LO = 4'd5;
    localparam logic [3:0] SP_POW_HI = 4'd12;
    localparam logic [3:0] SP_ADV    = 4'd13;

    localparam logic [cosc_pkg::LED_W-1:0] IDX_FIRST =
        cosc_pkg::LED_W'(1);
    localparam logic [cosc_pkg::LED_W-1:0] IDX_LAST_IN =
        cosc_pkg::LED_W'(cosc_pkg::LED_COUNT - 2);
    localparam logic [cosc_pkg::LED_W-1:0] IDX_END =
        cosc_pkg::LED_W'(cosc_pkg::LED_COUNT - 1);

    localparam logic [31:0] Q30_ONE_C = cosc_pkg::Q30_ONE;

    // configuration
    logic [cosc_pkg::CFG_W-1:0] freq_step_reg, freq_min_reg, freq_max_reg;

    // led state memories
    logic [cosc_pkg::PHASE_W-1:0] phase_mem [cosc_pkg::LED_COUNT];
    logic [cosc_pkg::FREQ_W-1:0]  freq_mem  [cosc_pkg::LED_COUNT];
    logic [cosc_pkg::LED_COUNT-1:0] valid_reg;
    logic [cosc_pkg::PHASE_W-1:0] rd_phase_reg;
    logic [cosc_pkg::FREQ_W-1:0]  rd_freq_reg;
    logic                         rd_valid_reg;

    logic [cosc_pkg::LED_W-1:0]   raddr;
    logic                         we;
    logic [cosc_pkg::LED_W-1:0]   waddr;
    logic [cosc_pkg::PHASE_W-1:0] wphase;
    logic [cosc_pkg::FREQ_W-1:0]  wfreq;

    // sequencer
    logic [2:0]                   state_reg;
    logic [3:0]                   step_reg;
    logic [cosc_pkg::LED_W-1:0]   idx_reg;
    logic                         end_reg;
    logic [cosc_pkg::DT_W-1:0]    dt_reg;
    logic [cosc_pkg::PHASE_W-1:0] own_phase_reg;
    logic [cosc_pkg::FREQ_W-1:0]  own_freq_reg;
    logic [cosc_pkg::PHASE_W-1:0] new_phase_reg;
    logic [cosc_pkg::PHASE_W-1:0] a_reg;
    logic                         far_reg;
    logic [31:0]                  v_reg, t_reg, c_reg, p_reg;
    logic [63:0]                  prod_reg;

    // output register
    logic                         m_tvalid_reg;
    logic [cosc_pkg::LED_W-1:0]   m_pix_reg;
    logic [cosc_pkg::BRIGHT_W-1:0] m_bright_reg;
    logic                         m_last_reg;

    logic [cosc_pkg::PHASE_W-1:0] eff_phase;
    logic [cosc_pkg::FREQ_W-1:0]  eff_freq;
    logic [cosc_pkg::PHASE_W-1:0] diff;
    logic [cosc_pkg::PHASE_W-1:0] a_next;
    logic signed [14:0]           f_nudge;
    logic signed [14:0]           f_hi;
    logic signed [14:0]           f_clamp;
    logic [31:0]                  mul_a, mul_b;
    logic [33:0]                  prod_sh;
    logic signed [34:0]           t_final;
    logic [46:0]                  bright_wide;
    logic [cosc_pkg::BRIGHT_W-1:0] bright;
    logic                         out_free;
    logic                         in_acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_bright_reg, m_pix_reg};
    assign m_tlast  = m_last_reg;

    assign eff_phase = rd_valid_reg ? rd_phase_reg : '0;
    assign eff_freq  = rd_valid_reg ? rd_freq_reg : cosc_pkg::FREQ_RESET;

    // frequency nudge toward the right neighbor, then clamp
    assign diff    = eff_phase - own_phase_reg;
    assign f_nudge = (diff <= 16'd32768)
                   ? $signed({2'b00, own_freq_reg}) + $signed({2'b00, freq_step_reg})
                   : $signed({2'b00, own_freq_reg}) - $signed({2'b00, freq_step_reg});
    assign f_hi    = (f_nudge > $signed({2'b00, freq_max_reg}))
                   ? $signed({2'b00, freq_max_reg}) : f_nudge;
    assign f_clamp = (f_hi < $signed({2'b00, freq_min_reg}))
                   ? $signed({2'b00, freq_min_reg}) : f_hi;

    // distance from zero phase, 0 .. half a turn
    assign a_next = own_phase_reg[15] ? (~own_phase_reg + 16'd1) : own_phase_reg;

    assign prod_sh = prod_reg[63:30];
    assign t_final = $signed({3'b000, Q30_ONE_C}) - $signed({1'b0, prod_sh});

    assign bright_wide = {p_reg[30:0], 16'h0000} - {15'd0, p_reg};
    assign bright      = far_reg ? '0 : bright_wide[45:30];

    always_comb begin
        case (step_reg) inside
            SP_SQ: begin
                mul_a = {16'd0, a_reg};
                mul_b = {16'd0, a_reg};
            end
            SP_C4: begin
                mul_a = cosc_pkg::COS_C4;
                mul_b = v_reg;
            end
            SP_C3, SP_C2, SP_C1: begin
                mul_a = t_reg;
                mul_b = v_reg;
            end
            [SP_POW_LO:SP_POW_HI]: begin
                mul_a = p_reg;
                mul_b = c_reg;
            end
            SP_ADV: begin
                mul_a = {19'd0, own_freq_reg};
                mul_b = {16'd0, dt_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        unique case (state_reg)
            ST_IDLE:  raddr = IDX_FIRST;
            ST_RDOWN: raddr = idx_reg + 1'b1;
            ST_EMIT:  raddr = (idx_reg == IDX_LAST_IN) ? '0 : idx_reg + 1'b1;
            ST_ACC:   raddr = IDX_END;
            default:  raddr = idx_reg;
        endcase
    end

    always_comb begin
        we     = 1'b0;
        waddr  = idx_reg;
        wphase = new_phase_reg;
        wfreq  = own_freq_reg;
        if (in_acc && s_tuser == cosc_pkg::OP_LOAD) begin
            we     = ({1'b0, s_tdata[5:0]} < 7'(cosc_pkg::LED_COUNT));
            waddr  = s_tdata[5:0];
            wphase = s_tdata[21:6];
            wfreq  = s_tdata[34:22];
        end else if (state_reg == ST_EMIT && out_free) begin
            we = 1'b1;
        end else if (state_reg == ST_ACC && step_reg == SP_ADV && end_reg) begin
            we     = 1'b1;
            wphase = own_phase_reg + prod_reg[27:12];
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            phase_mem[waddr] <= wphase;
            freq_mem[waddr]  <= wfreq;
        end
        rd_phase_reg <= phase_mem[raddr];
        rd_freq_reg  <= freq_mem[raddr];
        rd_valid_reg <= valid_reg[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_step_reg <= cosc_pkg::FREQ_STEP_RESET;
            freq_min_reg  <= cosc_pkg::FREQ_MIN_RESET;
            freq_max_reg  <= cosc_pkg::FREQ_MAX_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                cosc_pkg::CFG_FREQ_STEP: freq_step_reg <= cfg_wdata;
                cosc_pkg::CFG_FREQ_MIN:  freq_min_reg  <= cfg_wdata;
                cosc_pkg::CFG_FREQ_MAX:  freq_max_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // payload of the sequencer
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            prod_reg <= mul_a * mul_b;
        end
        if (in_acc) begin
            dt_reg <= s_tdata[50:35];
        end
        if (state_reg == ST_RDOWN) begin
            own_phase_reg <= eff_phase;
            own_freq_reg  <= eff_freq;
        end
        if (state_reg == ST_RDNB) begin
            own_freq_reg <= f_clamp[cosc_pkg::FREQ_W-1:0];
            a_reg        <= a_next;
            far_reg      <= (a_next >= 16'd16384);
        end
        if (state_reg == ST_ACC) begin
            case (step_reg)
                SP_SQ: v_reg <= {prod_reg[29:0], 2'b00};
                SP_C4: t_reg <= 32'(cosc_pkg::COS_C3 - prod_sh);
                SP_C3: t_reg <= 32'(cosc_pkg::COS_C2 - prod_sh);
                SP_C2: t_reg <= 32'(cosc_pkg::COS_C1 - prod_sh);
                SP_C1: begin
                    if (t_final < 0) begin
                        c_reg <= '0;
                        p_reg <= '0;
                    end else begin
                        c_reg <= t_final[31:0];
                        p_reg <= t_final[31:0];
                    end
                end
                SP_ADV: new_phase_reg <= own_phase_reg + prod_reg[27:12];
                default: p_reg <= prod_reg[61:30];
            endcase
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= SP_SQ;
            idx_reg   <= IDX_FIRST;
            end_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc && s_tuser == cosc_pkg::OP_TICK) begin
                        idx_reg   <= IDX_FIRST;
                        end_reg   <= 1'b0;
                        state_reg <= ST_RDOWN;
                    end
                end
                ST_RDOWN: begin
                    if (end_reg) begin
                        step_reg  <= SP_ADV;
                        state_reg <= ST_MUL;
                    end else begin
                        state_reg <= ST_RDNB;
                    end
                end
                ST_RDNB: begin
                    step_reg  <= SP_SQ;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (step_reg != SP_ADV) begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end else if (!end_reg) begin
                        state_reg <= ST_EMIT;
                    end else if (idx_reg == '0) begin
                        idx_reg   <= IDX_END;
                        state_reg <= ST_RDOWN;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        if (idx_reg == IDX_LAST_IN) begin
                            idx_reg <= '0;
                            end_reg <= 1'b1;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                        state_reg <= ST_RDOWN;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            m_pix_reg    <= idx_reg;
            m_bright_reg <= bright;
            m_last_reg   <= (idx_reg == IDX_LAST_IN);
        end
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cosc_pkg::*;

    typedef struct packed {
        logic [LED_W-1:0]    pixel;
        logic [BRIGHT_W-1:0] bright;
        logic                last;
    } pixel_t;

    class strip_scoreboard;
        logic [PHASE_W-1:0] phase_mem [LED_COUNT];
        logic [FREQ_W-1:0]  freq_mem [LED_COUNT];
        logic [CFG_W-1:0]   step_reg, min_reg, max_reg;
        pixel_t             pending [$];
        int                 errors;

        function void clear();
            step_reg = FREQ_STEP_RESET;
            min_reg  = FREQ_MIN_RESET;
            max_reg  = FREQ_MAX_RESET;
            for (int i = 0; i < LED_COUNT; i++) begin
                phase_mem[i] = '0;
                freq_mem[i]  = FREQ_RESET;
            end
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_FREQ_STEP) step_reg = val;
            else if (idx == CFG_FREQ_MIN) min_reg = val;
            else if (idx == CFG_FREQ_MAX) max_reg = val;
        endfunction

        function logic [BRIGHT_W-1:0] cos9(logic [PHASE_W-1:0] ph);
            longint ang, v, t, p, c;
            ang = (ph >= 32768) ? 65536 - ph : ph;
            if (ang >= 16384) return '0;
            v = (ang * ang) << 2;
            t = COS_C4;
            t = longint'(COS_C3) - ((t * v) >>> 30);
            t = longint'(COS_C2) - ((t * v) >>> 30);
            t = longint'(COS_C1) - ((t * v) >>> 30);
            t = longint'(Q30_ONE) - ((t * v) >>> 30);
            if (t < 0) t = 0;
            if (t > longint'(Q30_ONE)) t = Q30_ONE;
            c = t;
            p = c;
            for (int k = 0; k < 8; k++) p = (p * c) >> 30;
            return BRIGHT_W'((p * 65535) >> 30);
        endfunction

        function logic [PHASE_W-1:0] advance(logic [PHASE_W-1:0] ph,
                                             logic [FREQ_W-1:0] f, logic [DT_W-1:0] dt);
            longint prod;
            prod = (longint'(f) * longint'(dt)) >> 12;
            return PHASE_W'(longint'(ph) + prod);
        endfunction

        function void note_input(logic op, logic [S_TDATA_W-1:0] d);
            logic [LED_W-1:0]   led;
            logic [DT_W-1:0]    dt;
            logic [PHASE_W-1:0] diff;
            int                 f;
            pixel_t             px;
            led = d[5:0];
            dt  = d[50:35];
            if (op == OP_LOAD) begin
                phase_mem[led] = d[21:6];
                freq_mem[led]  = d[34:22];
                return;
            end
            for (int i = 1; i < LED_COUNT - 1; i++) begin
                diff = phase_mem[i+1] - phase_mem[i];
                px.pixel  = LED_W'(i);
                px.bright = cos9(phase_mem[i]);
                px.last   = (i == LED_COUNT - 2);
                f = int'(freq_mem[i]);
                if (diff <= 32768) f += int'(step_reg); else f -= int'(step_reg);
                if (f > int'(max_reg)) f = int'(max_reg);
                if (f < int'(min_reg)) f = int'(min_reg);
                freq_mem[i]  = FREQ_W'(f);
                phase_mem[i] = advance(phase_mem[i], freq_mem[i], dt);
                pending.push_back(px);
            end
            phase_mem[0] = advance(phase_mem[0], freq_mem[0], dt);
            phase_mem[LED_COUNT-1] = advance(phase_mem[LED_COUNT-1],
                                             freq_mem[LED_COUNT-1], dt);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d, logic l);
            pixel_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected pixel %0d bright %0d last %0b", $time,
                         d[5:0], d[21:6], l);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (d[5:0] !== want.pixel || d[21:6] !== want.bright || l !== want.last) begin
                $display("%0t: expected pixel %0d bright %0d last %0b, got %0d %0d %0b",
                         $time, want.pixel, want.bright, want.last, d[5:0], d[21:6], l);
                errors++;
            end
        endfunction
    endclass

    logic                    aclk = 0;
    logic                    aresetn = 0;
    logic                    s_tvalid = 0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic                    s_tuser = 0;
    logic                    m_tvalid;
    logic                    m_tready = 0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tlast;
    logic                    cfg_we = 0;
    logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
    logic [CFG_W-1:0]        cfg_wdata = '0;

    strip_scoreboard sb;
    int  send_idle = 0;
    int  recv_idle = 0;
    bit  hold_recv = 0;
    int  quiet_cycles = 0;

    always #1 aclk = ~aclk;

    coupled_oscillator_led_strip dut (.*);

    // sample both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= 20000) begin
                $display("[coupled_oscillator_led_strip] ERROR");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end

    // valid stays high between back-to-back transactions unless a random idle gap is drawn
    task automatic send_item(logic op, logic [LED_W-1:0] led, logic [PHASE_W-1:0] ph,
                             logic [FREQ_W-1:0] f, logic [DT_W-1:0] dt);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, dt, f, ph, led};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic stop_send();
        s_tvalid <= 0;
    endtask

    task automatic tick(logic [DT_W-1:0] dt);
        send_item(OP_TICK, LED_W'($urandom), PHASE_W'($urandom), FREQ_W'($urandom), dt);
    endtask

    task automatic load(logic [LED_W-1:0] led, logic [PHASE_W-1:0] ph,
                        logic [FREQ_W-1:0] f);
        send_item(OP_LOAD, led, ph, f, DT_W'($urandom));
    endtask

    task automatic drain();
        stop_send();
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (2100) @(negedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 0;
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic random_items(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(3) == 0) tick(DT_W'($urandom));
            else load(LED_W'($urandom), PHASE_W'($urandom), FREQ_W'($urandom));
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (3) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: extremes, half-turn difference, out-of-phase neighbors
        load(6'd0, 16'hFFFF, 13'h1FFF);
        load(6'd63, 16'h0000, 13'h0000);
        load(6'd1, 16'h0000, 13'd4096);
        load(6'd2, 16'h8000, 13'd4096);
        load(6'd3, 16'h4000, 13'd100);
        load(6'd4, 16'h3FFF, 13'd8000);
        load(6'd5, 16'hC001, 13'd2000);
        load(6'd6, 16'h8001, 13'd3000);
        tick(16'h0000);
        tick(16'hFFFF);
        tick(16'd1092);
        drain();

        // crossed clamp limits
        write_cfg(CFG_FREQ_STEP, 13'h1FFF);
        write_cfg(CFG_FREQ_MIN, 13'd6000);
        write_cfg(CFG_FREQ_MAX, 13'd100);
        load(6'd10, 16'h1234, 13'd50);
        tick(16'd3000);
        tick(DT_W'($urandom));
        drain();

        write_cfg(CFG_FREQ_STEP, 13'd0);
        write_cfg(CFG_FREQ_MIN, 13'd0);
        write_cfg(CFG_FREQ_MAX, 13'h1FFF);
        tick(DT_W'($urandom));
        drain();

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_recv = 1;
                repeat (400) @(negedge aclk);
                hold_recv = 0;
            end
            begin
                tick(DT_W'($urandom));
                tick(DT_W'($urandom));
                load(6'd7, PHASE_W'($urandom), FREQ_W'($urandom));
                stop_send();
            end
        join
        drain();

        write_cfg(CFG_FREQ_STEP, 13'd410);
        write_cfg(CFG_FREQ_MIN, 13'd1843);
        write_cfg(CFG_FREQ_MAX, 13'd4506);
        send_idle = 15;
        recv_idle = 54;
        random_items(60);
        drain();

        write_cfg(CFG_FREQ_STEP, CFG_W'($urandom));
        write_cfg(CFG_FREQ_MIN, CFG_W'($urandom_range(4000)));
        write_cfg(CFG_FREQ_MAX, CFG_W'($urandom_range(8191, 4000)));
        send_idle = 54;
        recv_idle = 15;
        random_items(60);
        drain();

        send_idle = 0;
        recv_idle = 0;
        random_items(60);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[coupled_oscillator_led_strip] OK");
        else
            $display("[coupled_oscillator_led_strip] ERROR");
        $finish;
    end
endmodule
